// ===== rtl/ats2e_pkg.sv =====
// Types, constants and layout tables shared by the timestamp converter.
`timescale 1ns / 1ps
`default_nettype none

package ats2e_pkg;

  // Layout codes written to the format register
  localparam logic [2:0] FMT_DATE_PLAIN   = 3'd0;
  localparam logic [2:0] FMT_DATE_DASH    = 3'd1;
  localparam logic [2:0] FMT_DT_PLAIN     = 3'd2;
  localparam logic [2:0] FMT_DT_DASH      = 3'd3;
  localparam logic [2:0] FMT_DT_MICRO     = 3'd4;
  localparam logic [2:0] FMT_US_MICRO     = 3'd5;
  localparam logic [2:0] FMT_DURATION     = 3'd6;
  localparam logic [2:0] FMT_NONE         = 3'd7;
  localparam logic [2:0] FMT_RESET        = FMT_DT_DASH;

  // Error codes
  localparam logic [2:0] ERR_OK     = 3'd0;
  localparam logic [2:0] ERR_LENGTH = 3'd1;
  localparam logic [2:0] ERR_YEAR   = 3'd2;
  localparam logic [2:0] ERR_MONTH  = 3'd3;
  localparam logic [2:0] ERR_DAY    = 3'd4;
  localparam logic [2:0] ERR_DIGIT  = 3'd5;

  localparam int unsigned YEAR_SPAN = 67;
  localparam logic [13:0] EPOCH_YEAR = 14'd1970;
  localparam logic [13:0] YEAR_MIN   = 14'(1970 + 1);
  localparam logic [13:0] YEAR_MAX   = 14'(1970 + YEAR_SPAN);
  localparam logic [6:0]  MONTH_MAX  = 7'd12;

  localparam logic [29:0] SEC_PER_HOUR  = 30'd3600;
  localparam logic [29:0] SEC_PER_MIN   = 30'd60;
  localparam logic [29:0] SEC_PER_DAY   = 30'(24 * 60 * 60);
  localparam logic [29:0] DAYS_PER_YEAR = 30'd365;
  localparam logic [29:0] NS_PER_SEC    = 30'd1000000000;
  localparam logic [29:0] NS_PER_US     = 30'd1000;

  typedef enum logic [2:0] {
    K_SEP, K_YEAR, K_MONTH, K_DAY, K_HOUR, K_MINUTE, K_SECOND, K_MICRO
  } kind_e;

  typedef enum logic [2:0] {
    CS_IDLE, CS_TOD_H, CS_TOD_M, CS_DAYS, CS_SEC, CS_NS, CS_US, CS_HOLD
  } conv_state_e;

  // Per-string state handed from the parser to the converter
  typedef struct packed {
    logic [2:0]  mode;
    logic [4:0]  pos;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic [19:0] micro;
    logic        digit_err;
  } fields_t;

  function automatic logic [4:0] layout_len(input logic [2:0] mode);
    logic [4:0] len;
    case (mode)
      FMT_DATE_PLAIN: len = 5'd8;
      FMT_DATE_DASH:  len = 5'd10;
      FMT_DT_PLAIN:   len = 5'd17;
      FMT_DT_DASH:    len = 5'd19;
      FMT_DT_MICRO:   len = 5'd26;
      FMT_US_MICRO:   len = 5'd26;
      FMT_DURATION:   len = 5'd15;
      default:        len = 5'd0;
    endcase
    return len;
  endfunction

  // Field that a character position feeds; separators and positions
  // past the layout map to K_SEP
  function automatic kind_e layout_kind(input logic [2:0] mode, input logic [4:0] pos);
    kind_e k;
    k = K_SEP;
    case (mode)
      FMT_DATE_PLAIN: begin
        case (pos) inside
          [5'd0:5'd3]: k = K_YEAR;
          [5'd4:5'd5]: k = K_MONTH;
          [5'd6:5'd7]: k = K_DAY;
          default:     k = K_SEP;
        endcase
      end
      FMT_DATE_DASH: begin
        case (pos) inside
          [5'd0:5'd3]: k = K_YEAR;
          [5'd5:5'd6]: k = K_MONTH;
          [5'd8:5'd9]: k = K_DAY;
          default:     k = K_SEP;
        endcase
      end
      FMT_DT_PLAIN: begin
        case (pos) inside
          [5'd0:5'd3]:   k = K_YEAR;
          [5'd4:5'd5]:   k = K_MONTH;
          [5'd6:5'd7]:   k = K_DAY;
          [5'd9:5'd10]:  k = K_HOUR;
          [5'd12:5'd13]: k = K_MINUTE;
          [5'd15:5'd16]: k = K_SECOND;
          default:       k = K_SEP;
        endcase
      end
      FMT_DT_DASH, FMT_DT_MICRO: begin
        case (pos) inside
          [5'd0:5'd3]:   k = K_YEAR;
          [5'd5:5'd6]:   k = K_MONTH;
          [5'd8:5'd9]:   k = K_DAY;
          [5'd11:5'd12]: k = K_HOUR;
          [5'd14:5'd15]: k = K_MINUTE;
          [5'd17:5'd18]: k = K_SECOND;
          [5'd20:5'd25]: k = (mode == FMT_DT_MICRO) ? K_MICRO : K_SEP;
          default:       k = K_SEP;
        endcase
      end
      FMT_US_MICRO: begin
        case (pos) inside
          [5'd0:5'd1]:   k = K_MONTH;
          [5'd3:5'd4]:   k = K_DAY;
          [5'd6:5'd9]:   k = K_YEAR;
          [5'd11:5'd12]: k = K_HOUR;
          [5'd14:5'd15]: k = K_MINUTE;
          [5'd17:5'd18]: k = K_SECOND;
          [5'd20:5'd25]: k = K_MICRO;
          default:       k = K_SEP;
        endcase
      end
      FMT_DURATION: begin
        case (pos) inside
          [5'd0:5'd1]:  k = K_HOUR;
          [5'd3:5'd4]:  k = K_MINUTE;
          [5'd6:5'd7]:  k = K_SECOND;
          [5'd9:5'd14]: k = K_MICRO;
          default:      k = K_SEP;
        endcase
      end
      default: k = K_SEP;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] month_days(input logic [6:0] month, input logic leap);
    logic [4:0] n;
    case (month) inside
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: n = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    n = 5'd30;
      7'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [6:0] month);
    logic [8:0] n;
    case (month)
      7'd2:    n = 9'd31;
      7'd3:    n = 9'd59;
      7'd4:    n = 9'd90;
      7'd5:    n = 9'd120;
      7'd6:    n = 9'd151;
      7'd7:    n = 9'd181;
      7'd8:    n = 9'd212;
      7'd9:    n = 9'd243;
      7'd10:   n = 9'd273;
      7'd11:   n = 9'd304;
      7'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ats2e_conv.sv =====
// Checks a finished string and converts it to nanoseconds with one shared multiply-add.
`timescale 1ns / 1ps
`default_nettype none

module ats2e_conv (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              ack_i,
  input  wire ats2e_pkg::fields_t fld_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [61:0]            nanoseconds_o,
  output logic [2:0]             error_code_o
);
  import ats2e_pkg::*;

  conv_state_e state_q, state_d;
  logic [61:0] acc_q, acc_d;
  logic [18:0] tod_q, tod_d;

  logic [31:0] op_a;
  logic [29:0] op_b;
  logic [61:0] op_c;
  logic [61:0] mac_res;

  logic        leap;
  logic [13:0] year_off;
  logic [6:0]  yr;
  logic [7:0]  yr_p1;
  logic [9:0]  small_sum;
  logic [4:0]  limit;
  logic [2:0]  err;

  // shared multiply-add
  assign mac_res = 62'(op_a) * 62'(op_b) + op_c;

  assign leap     = (fld_i.year[1:0] == 2'b00);
  assign year_off = fld_i.year - EPOCH_YEAR;
  assign yr       = year_off[6:0];
  assign yr_p1    = {1'b0, yr} + 8'd1;
  assign limit    = month_days(fld_i.month, leap);
  assign small_sum = 10'(yr_p1[7:2]) + 10'(days_before_month(fld_i.month))
                   + 10'((leap && fld_i.month >= 7'd3) ? 1'b1 : 1'b0)
                   + 10'(fld_i.day) - 10'd1;

  always_comb begin
    if (fld_i.mode == FMT_NONE || fld_i.pos != layout_len(fld_i.mode)) begin
      err = ERR_LENGTH;
    end else if (fld_i.digit_err) begin
      err = ERR_DIGIT;
    end else if (fld_i.mode == FMT_DURATION) begin
      err = ERR_OK;
    end else if (fld_i.year < YEAR_MIN || fld_i.year > YEAR_MAX) begin
      err = ERR_YEAR;
    end else if (fld_i.month == 7'd0 || fld_i.month > MONTH_MAX) begin
      err = ERR_MONTH;
    end else if (fld_i.day == 7'd0 || fld_i.day > 7'(limit)) begin
      err = ERR_DAY;
    end else begin
      err = ERR_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    tod_q <= tod_d;
  end

  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    tod_d   = tod_q;
    op_a    = '0;
    op_b    = '0;
    op_c    = '0;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) state_d = CS_TOD_H;
      end
      CS_TOD_H: begin
        op_a    = 32'(fld_i.hour);
        op_b    = SEC_PER_HOUR;
        op_c    = 62'(fld_i.second);
        acc_d   = mac_res;
        state_d = CS_TOD_M;
      end
      CS_TOD_M: begin
        op_a    = 32'(fld_i.minute);
        op_b    = SEC_PER_MIN;
        op_c    = acc_q;
        acc_d   = mac_res;
        state_d = CS_DAYS;
      end
      CS_DAYS: begin
        // days since epoch; zero for a duration
        tod_d   = acc_q[18:0];
        op_a    = (fld_i.mode == FMT_DURATION) ? 32'd0 : 32'(yr);
        op_b    = DAYS_PER_YEAR;
        op_c    = (fld_i.mode == FMT_DURATION) ? 62'd0 : 62'(small_sum);
        acc_d   = mac_res;
        state_d = CS_SEC;
      end
      CS_SEC: begin
        op_a    = acc_q[31:0];
        op_b    = SEC_PER_DAY;
        op_c    = 62'(tod_q);
        acc_d   = mac_res;
        state_d = CS_NS;
      end
      CS_NS: begin
        op_a    = acc_q[31:0];
        op_b    = NS_PER_SEC;
        acc_d   = mac_res;
        state_d = CS_US;
      end
      CS_US: begin
        op_a    = 32'(fld_i.micro);
        op_b    = NS_PER_US;
        op_c    = acc_q;
        acc_d   = mac_res;
        state_d = CS_HOLD;
      end
      CS_HOLD: begin
        if (ack_i) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  assign busy_o        = (state_q != CS_IDLE);
  assign done_o        = (state_q == CS_HOLD);
  assign error_code_o  = err;
  assign nanoseconds_o = (err == ERR_OK) ? acc_q : 62'd0;

endmodule

`default_nettype wire

// ===== rtl/ascii_timestamp_to_epoch_ns_unit.sv =====
// Top level: byte parser, format register, converter and output register.
// Flow: a non-final byte is taken while the converter is idle; after the final
// byte the converter runs six multiply-add steps on its one shared unit and
// holds the result until it moves into the output register.
// A new string's bytes are not taken before then: in_stall_o is high while
// the conversion runs and until the result moves into the output register.
// Reset: format 3 (dashed date-time), parser accumulators, output valid clear.
`timescale 1ns / 1ps
`default_nettype none

module ascii_timestamp_to_epoch_ns_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_format_mode_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_byte_i,
  input  wire logic        last_char_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [61:0]      nanoseconds_o,
  output logic [2:0]       error_code_o
);
  import ats2e_pkg::*;

  logic [2:0]  mode_q;
  fields_t     fld_q, fld_d;
  logic        in_acc;
  logic        is_digit;
  logic [3:0]  digit;
  kind_e       kind;

  logic        conv_busy, conv_done, conv_ack;
  logic [61:0] conv_ns;
  logic [2:0]  conv_err;

  logic        out_valid_q;
  logic [61:0] ns_q;
  logic [2:0]  err_q;

  // bytes are taken only while the converter is idle
  assign in_stall_o = conv_busy;
  assign in_acc     = in_valid_i && !in_stall_o;

  // result moves into the output register once that register is free
  assign conv_ack = conv_done && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= FMT_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_format_mode_i;
    end
  end

  // Byte decode: the position picks the field; a non-digit in a digit
  // position adds zero and flags the string
  assign is_digit = (char_byte_i >= 8'h30) && (char_byte_i <= 8'h39);
  assign digit    = is_digit ? char_byte_i[3:0] : 4'd0;
  assign kind     = layout_kind(mode_q, fld_q.pos);

  always_comb begin
    fld_d      = fld_q;
    fld_d.mode = mode_q;
    if (conv_ack) begin
      fld_d      = '0;
      fld_d.mode = mode_q;
    end else if (in_acc) begin
      case (kind)
        K_YEAR:   fld_d.year   = 14'(fld_q.year * 4'd10) + 14'(digit);
        K_MONTH:  fld_d.month  = 7'(fld_q.month * 4'd10) + 7'(digit);
        K_DAY:    fld_d.day    = 7'(fld_q.day * 4'd10) + 7'(digit);
        K_HOUR:   fld_d.hour   = 7'(fld_q.hour * 4'd10) + 7'(digit);
        K_MINUTE: fld_d.minute = 7'(fld_q.minute * 4'd10) + 7'(digit);
        K_SECOND: fld_d.second = 7'(fld_q.second * 4'd10) + 7'(digit);
        K_MICRO:  fld_d.micro  = 20'(fld_q.micro * 4'd10) + 20'(digit);
        default:  ;
      endcase
      if (kind != K_SEP && !is_digit) fld_d.digit_err = 1'b1;
      // position saturates; past any layout it only feeds the length check
      if (fld_q.pos != 5'd31) fld_d.pos = fld_q.pos + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fld_q <= fields_t'{mode: FMT_RESET, default: '0};
    end else begin
      fld_q <= fld_d;
    end
  end

  ats2e_conv u_conv (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (in_acc && last_char_i),
    .ack_i         (conv_ack),
    .fld_i         (fld_q),
    .busy_o        (conv_busy),
    .done_o        (conv_done),
    .nanoseconds_o (conv_ns),
    .error_code_o  (conv_err)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (conv_ack) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_ack) begin
      ns_q  <= conv_ns;
      err_q <= conv_err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign nanoseconds_o = ns_q;
  assign error_code_o  = err_q;

endmodule

`default_nettype wire

// ===== tb/ascii_timestamp_to_epoch_ns_unit_tb.sv =====
// Self-checking testbench for the ASCII timestamp to epoch-nanoseconds converter.
`timescale 1ns / 1ps

module ascii_timestamp_to_epoch_ns_unit_tb;
  import ats2e_pkg::*;

  // Hard stop for a hung handshake
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_PHASE_CHARS = 80;

  typedef byte unsigned bytes_t[$];

  // One converted timestamp as the block should deliver it
  typedef struct {
    logic [61:0] ns;
    logic [2:0]  code;
  } stamp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_format_mode_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  char_byte_i;
  logic        last_char_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [61:0] nanoseconds_o;
  logic [2:0]  error_code_o;

  ascii_timestamp_to_epoch_ns_unit uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_format_mode_i (cfg_format_mode_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .char_byte_i       (char_byte_i),
    .last_char_i       (last_char_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .nanoseconds_o     (nanoseconds_o),
    .error_code_o      (error_code_o)
  );

  // Position maps per format: Y year, M month, D day, h hour, m minute,
  // s second, u microsecond; anything else is a separator. Format 7 has none.
  string layouts[8] = '{
    "YYYYMMDD",
    "YYYY-MM-DD",
    "YYYYMMDD hh:mm:ss",
    "YYYY-MM-DD hh:mm:ss",
    "YYYY-MM-DD hh:mm:ss.uuuuuu",
    "MM-DD-YYYY hh:mm:ss.uuuuuu",
    "hh:mm:ss.uuuuuu",
    ""
  };
  int unsigned days_in_month[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  int unsigned days_ahead[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  // Shadow of the parser state, advanced on every accepted item
  logic [2:0]  cur_fmt;
  logic [4:0]  str_pos;
  logic [13:0] acc_year;
  logic [6:0]  acc_month;
  logic [6:0]  acc_day;
  logic [6:0]  acc_hour;
  logic [6:0]  acc_min;
  logic [6:0]  acc_sec;
  logic [19:0] acc_micro;
  logic        saw_bad_digit;

  stamp_t expected_stamps[$];

  int failures;
  int chars_sent;
  int strings_sent;
  int results_seen;
  int code_seen[8];
  int gap_max;      // 0: sender streams back to back
  int burst_left;
  int stall_style;  // 0 none, 1 light, 2 heavy
  int stall_run;
  int free_run;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic kind_e field_at(input logic [2:0] mode, input int p);
    kind_e k;
    byte unsigned tag;
    tag = layouts[mode][p];
    case (tag)
      "Y":     k = K_YEAR;
      "M":     k = K_MONTH;
      "D":     k = K_DAY;
      "h":     k = K_HOUR;
      "m":     k = K_MINUTE;
      "s":     k = K_SECOND;
      "u":     k = K_MICRO;
      default: k = K_SEP;
    endcase
    return k;
  endfunction

  // Checks the finished string and works out nanoseconds and error code.
  // Order of checks: length, non-digit, then (dates only) year, month, day.
  function automatic stamp_t convert_string(input int count);
    stamp_t r;
    logic [63:0] tod;
    logic [63:0] days;
    int unsigned y;
    int unsigned lim;
    bit leap;
    r.ns = '0;
    r.code = ERR_OK;
    tod = 64'(acc_hour) * 3600 + 64'(acc_min) * 60 + 64'(acc_sec);
    if (cur_fmt == FMT_NONE || count != layouts[cur_fmt].len()) begin
      r.code = ERR_LENGTH;
    end else if (saw_bad_digit) begin
      r.code = ERR_DIGIT;
    end else if (cur_fmt == FMT_DURATION) begin
      r.ns = 62'(tod * 64'd1000000000 + 64'(acc_micro) * 64'd1000);
    end else if (acc_year < 1971 || acc_year > 1970 + YEAR_SPAN) begin
      r.code = ERR_YEAR;
    end else if (acc_month < 1 || acc_month > 12) begin
      r.code = ERR_MONTH;
    end else begin
      leap = (acc_year % 4) == 0;
      lim = days_in_month[acc_month];
      if (leap && acc_month == 2) lim = 29;
      if (acc_day == 0 || acc_day > lim) begin
        r.code = ERR_DAY;
      end else begin
        y = acc_year - 1970;
        days = 64'(y) * 365 + (y + 1) / 4 + days_ahead[acc_month]
             + ((leap && acc_month >= 3) ? 1 : 0) + (acc_day - 1);
        r.ns = 62'((days * 86400 + tod) * 64'd1000000000 + 64'(acc_micro) * 64'd1000);
      end
    end
    return r;
  endfunction

  function automatic void clear_string();
    str_pos = '0;
    acc_year = '0;
    acc_month = '0;
    acc_day = '0;
    acc_hour = '0;
    acc_min = '0;
    acc_sec = '0;
    acc_micro = '0;
    saw_bad_digit = 1'b0;
  endfunction

  // Folds one accepted character into the shadow state; on the last one the
  // expected result is queued.
  function automatic void absorb_char(input logic [7:0] c, input logic last);
    kind_e k;
    bit is_dig;
    logic [3:0] d;
    int count;
    count = str_pos + 1;
    if (str_pos < layouts[cur_fmt].len()) begin
      k = field_at(cur_fmt, str_pos);
      is_dig = (c >= "0" && c <= "9");
      d = is_dig ? 4'(c - "0") : 4'd0;
      case (k)
        K_YEAR:   acc_year  = 14'(acc_year * 10 + d);
        K_MONTH:  acc_month = 7'(acc_month * 10 + d);
        K_DAY:    acc_day   = 7'(acc_day * 10 + d);
        K_HOUR:   acc_hour  = 7'(acc_hour * 10 + d);
        K_MINUTE: acc_min   = 7'(acc_min * 10 + d);
        K_SECOND: acc_sec   = 7'(acc_sec * 10 + d);
        K_MICRO:  acc_micro = 20'(acc_micro * 10 + d);
        default:  ;
      endcase
      if (k != K_SEP && !is_dig) saw_bad_digit = 1'b1;
    end
    if (str_pos != 5'd31) str_pos = str_pos + 5'd1;  // counter saturates
    if (last) begin
      expected_stamps.push_back(convert_string(count));
      clear_string();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Presents one item and holds it until taken. Valid is left high so the
  // next item can follow in the very next cycle.
  task automatic send_char(input logic [7:0] c, input logic last);
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    last_char_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    absorb_char(c, last);
    chars_sent++;
  endtask

  // Sends a whole string in bursts; gaps land between any two characters
  task automatic send_stamp(input bytes_t q);
    foreach (q[i]) begin
      if (burst_left == 0) begin
        if (gap_max > 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_char(q[i], i == q.size() - 1);
    end
    strings_sent++;
  endtask

  task automatic send_text(input string s);
    bytes_t q;
    foreach (s[i]) q.push_back(s[i]);
    send_stamp(q);
  endtask

  // Holds the sender off until every queued result has been delivered
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk_i);
  endtask

  // Format register is only touched once the block is quiet: drain, then idle.
  task automatic set_format(input logic [2:0] m);
    drain();
    repeat (16) @(posedge clk_i);
    cfg_we_i          <= 1'b1;
    cfg_format_mode_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_fmt = m;
  endtask

  // Random timestamp for a format: mostly plausible fields, sometimes the full
  // width of every field, then an occasional bad byte, cut or overrun.
  function automatic bytes_t make_stamp(input logic [2:0] mode);
    bytes_t q;
    string s;
    int yr, mo, dy, hh, mi, ss, us, k;
    if ($urandom_range(0, 3) != 0) begin
      yr = $urandom_range(1965, 2042);
      mo = $urandom_range(0, 13);
      dy = $urandom_range(0, 32);
      hh = $urandom_range(0, 23);
      mi = $urandom_range(0, 59);
      ss = $urandom_range(0, 59);
    end else begin
      yr = $urandom_range(0, 9999);
      mo = $urandom_range(0, 99);
      dy = $urandom_range(0, 99);
      hh = $urandom_range(0, 99);
      mi = $urandom_range(0, 99);
      ss = $urandom_range(0, 99);
    end
    us = $urandom_range(0, 999999);
    case (mode)
      FMT_DATE_PLAIN: s = $sformatf("%04d%02d%02d", yr, mo, dy);
      FMT_DATE_DASH:  s = $sformatf("%04d-%02d-%02d", yr, mo, dy);
      FMT_DT_PLAIN:   s = $sformatf("%04d%02d%02d %02d:%02d:%02d", yr, mo, dy, hh, mi, ss);
      FMT_DT_DASH:    s = $sformatf("%04d-%02d-%02d %02d:%02d:%02d", yr, mo, dy, hh, mi, ss);
      FMT_DT_MICRO:   s = $sformatf("%04d-%02d-%02d %02d:%02d:%02d.%06d",
                                    yr, mo, dy, hh, mi, ss, us);
      FMT_US_MICRO:   s = $sformatf("%02d-%02d-%04d %02d:%02d:%02d.%06d",
                                    mo, dy, yr, hh, mi, ss, us);
      FMT_DURATION:   s = $sformatf("%02d:%02d:%02d.%06d", hh, mi, ss, us);
      default:        s = "";
    endcase
    foreach (s[i]) q.push_back(s[i]);
    if (q.size() == 0) begin
      // no layout: pure noise of up to 34 bytes, past the position counter's range
      repeat ($urandom_range(1, 34)) q.push_back(8'($urandom));
    end else begin
      k = $urandom_range(0, 19);
      if (k < 3) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (k == 3) q = q[0:$urandom_range(0, q.size() - 2)];
      else if (k == 4) repeat ($urandom_range(1, 20)) q.push_back(8'($urandom));
    end
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver stalls in runs; style picks how often and for how long
  always @(posedge clk_i) begin
    if (stall_run > 0) begin
      out_stall_i <= 1'b1;
      stall_run--;
    end else if (free_run > 0) begin
      out_stall_i <= 1'b0;
      free_run--;
    end else begin
      out_stall_i <= 1'b0;
      case (stall_style)
        1: begin
          stall_run = $urandom_range(1, 3);
          free_run  = $urandom_range(2, 10);
        end
        2: begin
          stall_run = $urandom_range(1, 12);
          free_run  = $urandom_range(0, 4);
        end
        default: begin
          stall_run = 0;
          free_run  = 32;
        end
      endcase
    end
  end

  // Every delivered result is matched against the oldest expectation
  always @(posedge clk_i) begin
    stamp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_stamps.size() == 0) begin
        $error("unexpected result: nanoseconds %0d, error_code %0d",
               nanoseconds_o, error_code_o);
        failures++;
      end else begin
        want = expected_stamps.pop_front();
        if (nanoseconds_o !== want.ns) begin
          $error("nanoseconds: expected %0d, got %0d", want.ns, nanoseconds_o);
          failures++;
        end
        if (error_code_o !== want.code) begin
          $error("error_code: expected %0d, got %0d", want.code, error_code_o);
          failures++;
        end
        results_seen++;
        code_seen[want.code]++;
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("ascii_timestamp_to_epoch_ns_unit_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No register write yet: the dashed date-time layout must be in force
  task automatic test_reset_format();
    send_text("2000-02-29 23:59:59");
    send_text("1971-01-01 00:00:00");
  endtask

  // Date checks on the shortest layout: year bounds, leap day, day zero,
  // month range, non-digit, short string, wide year
  task automatic test_date_checks();
    set_format(FMT_DATE_PLAIN);
    send_text("19710101");
    send_text("20371231");
    send_text("19701231");
    send_text("20380101");
    send_text("20240229");
    send_text("20230229");
    send_text("20230100");
    send_text("20230001");
    send_text("20231301");
    send_text("2023a101");
    send_text("99999999");
    send_text("2023");
  endtask

  // Strings for each remaining layout, with field extremes and an overrun
  task automatic test_layouts();
    set_format(FMT_DATE_DASH);
    send_text("2037-12-31");
    send_text("2001-02-03--------------------------");  // length past position limit
    set_format(FMT_DT_PLAIN);
    send_text("20370228 23:59:59");
    set_format(FMT_DT_MICRO);
    send_text("1971-01-01 00:00:00.999999");
    send_text("1999-12-31 23:59:59.99x999");
    set_format(FMT_US_MICRO);
    send_text("12-31-2037 99:99:99.999999");
    set_format(FMT_DURATION);
    send_text("99:99:99.999999");
    send_text("00:00:00.000000");
    send_text("1970-01-01");  // wrong length in duration layout
  endtask

  // Format 7 has no layout: every string is a length error
  task automatic test_unused_format();
    set_format(FMT_NONE);
    send_text("5");
    send_text("20240101");
  endtask

  // Random phases across all formats, each with its own idling profile
  task automatic test_random_streams();
    logic [2:0] plan[10] = '{FMT_DATE_PLAIN, FMT_DURATION, FMT_NONE, FMT_DT_PLAIN,
                             FMT_DT_MICRO, FMT_US_MICRO, FMT_DATE_DASH, FMT_DT_DASH,
                             FMT_DT_MICRO, FMT_DATE_PLAIN};
    int budget;
    for (int p = 0; p < 10; p++) begin
      set_format(plan[p]);
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(2, 6);
      stall_style = p % 3;
      budget = chars_sent + RANDOM_PHASE_CHARS;
      while (chars_sent < budget) begin
        send_stamp(make_stamp(plan[p]));
        if ($urandom_range(0, 19) == 0) drain();
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_format_mode_i = FMT_RESET;
    in_valid_i        = 1'b0;
    char_byte_i       = 8'h00;
    last_char_i       = 1'b0;
    out_stall_i       = 1'b0;
    failures     = 0;
    chars_sent   = 0;
    strings_sent = 0;
    results_seen = 0;
    foreach (code_seen[i]) code_seen[i] = 0;
    gap_max     = 3;
    burst_left  = 0;
    stall_style = 1;
    stall_run   = 0;
    free_run    = 0;
    cur_fmt     = FMT_RESET;
    clear_string();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_format();
    test_date_checks();
    test_layouts();
    test_unused_format();
    test_random_streams();

    drain();
    repeat (24) @(posedge clk_i);
    if (expected_stamps.size() != 0) begin
      $error("%0d results never arrived", expected_stamps.size());
      failures += expected_stamps.size();
    end

    $display("Run covered %0d characters in %0d strings over all eight formats.",
             chars_sent, strings_sent);
    $display("Results checked: %0d (ok %0d, length %0d, year %0d, month %0d, day %0d, digit %0d).",
             results_seen, code_seen[ERR_OK], code_seen[ERR_LENGTH], code_seen[ERR_YEAR],
             code_seen[ERR_MONTH], code_seen[ERR_DAY], code_seen[ERR_DIGIT]);
    if (failures == 0) begin
      $display("ascii_timestamp_to_epoch_ns_unit_tb: PASS");
    end else begin
      $display("ascii_timestamp_to_epoch_ns_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== ascii_timestamp_to_epoch_ns_unit.f =====
rtl/ats2e_pkg.sv
rtl/ats2e_conv.sv
rtl/ascii_timestamp_to_epoch_ns_unit.sv
tb/ascii_timestamp_to_epoch_ns_unit_tb.sv
